// ===== hw/rtl/crc8frr_pkg.sv =====
`default_nettype none

package crc8frr_pkg;

	localparam int BUF_DEPTH_DEF = 64;
	localparam int RECORD_BYTES = 13;
	localparam int HDR_BYTES = 2;

	localparam logic [7:0] START_BYTE = 8'hAA;
	localparam logic [7:0] END_BYTE = 8'h55;
	localparam logic [7:0] CRC_POLY = 8'h07;

	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
	localparam logic [7:0] TYPE_RESET = 8'h20;
	localparam logic [15:0] TICKS_MAX = 16'hFFFF;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_TYPE = 1'b1;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_UPDATED = 3'd1;
	localparam logic [2:0] EV_OTHER = 3'd2;
	localparam logic [2:0] EV_CRC_ERR = 3'd3;
	localparam logic [2:0] EV_BAD_END = 3'd4;
	localparam logic [2:0] EV_OVERFLOW = 3'd5;
	localparam logic [2:0] EV_EXPIRED = 3'd6;

	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crc8_framed_record_receiver.sv =====
`default_nettype none

// Parses start/end delimited frames (0xAA, type, length, payload, CRC-8 with
// polynomial 0x07, 0x55) from a stream of received bytes and time ticks, and
// holds the last record of the configured type: a count byte and three
// big-endian 32-bit words. Every input word yields exactly one output word
// carrying an event code and the held record as it stands after that word.
// The block takes one input word per clock cycle while the output is not
// stalled; each word passes through the input register and then the result
// register, with the combinational parser and CRC update between them.
// Ready on the input side follows the output side, so a stalled output
// stops input after the two internal registers fill. The held record clears
// once timeout_ticks ticks have passed since the last update.
module crc8_framed_record_receiver #(
	parameter int BUF_DEPTH = crc8frr_pkg::BUF_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,

	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata,      // rx_byte
	input wire logic s_tuser,            // cmd

	output logic m_tvalid,
	input wire logic m_tready,
	// held_count, distance_bits, target_x_bits, target_y_bits
	output logic [103:0] m_tdata,
	output logic [2:0] m_tuser,          // frame_event

	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [15:0] cfg_data
);

	localparam int IDX_W = $clog2(BUF_DEPTH + 1);
	localparam int CMP_W = (IDX_W > 9) ? IDX_W + 1 : 10;
	localparam int CAP_W = $clog2(crc8frr_pkg::RECORD_BYTES);

	logic [15:0] timeout_q;
	logic [7:0] rec_type_q;

	logic in_valid_s1;
	logic in_cmd_s1;
	logic [7:0] in_byte_s1;
	logic out_valid_q;
	logic [2:0] event_q;
	logic adv;

	logic in_frame_q, in_frame_n;
	logic [IDX_W-1:0] idx_q, idx_n;
	logic [7:0] ftype_q, ftype_n;
	logic [7:0] flen_q, flen_n;
	logic [7:0] crc_q, crc_n;
	logic [7:0] rcrc_q, rcrc_n;
	logic [7:0] cap_q [crc8frr_pkg::RECORD_BYTES];
	logic cap_we;
	logic [CAP_W-1:0] cap_addr;
	logic [7:0] count_q, count_n;
	logic [31:0] word_q [3];
	logic [31:0] word_n [3];
	logic [15:0] ticks_q, ticks_n;
	logic [15:0] ticks_inc;
	logic ever_q, ever_n;
	logic [2:0] event_n;
	logic [CMP_W-1:0] idx_c;
	logic [CMP_W-1:0] len_c;

	assign cfg_ready = 1'b1;
	assign adv = in_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || adv;

	assign m_tvalid = out_valid_q;
	assign m_tuser = event_q;
	assign m_tdata = {word_q[2], word_q[1], word_q[0], count_q};

	assign idx_c = CMP_W'(idx_q);
	assign len_c = CMP_W'(flen_q);
	assign ticks_inc = (ticks_q != crc8frr_pkg::TICKS_MAX) ? ticks_q + 16'd1 : ticks_q;

	always_comb begin
		in_frame_n = in_frame_q;
		idx_n = idx_q;
		ftype_n = ftype_q;
		flen_n = flen_q;
		crc_n = crc_q;
		rcrc_n = rcrc_q;
		count_n = count_q;
		word_n = word_q;
		ticks_n = ticks_q;
		ever_n = ever_q;
		event_n = crc8frr_pkg::EV_NONE;
		cap_we = 1'b0;
		cap_addr = CAP_W'(idx_q - IDX_W'(crc8frr_pkg::HDR_BYTES));
		if (in_cmd_s1 == crc8frr_pkg::CMD_TICK) begin
			if (ever_q) begin
				ticks_n = ticks_inc;
				if (ticks_inc >= timeout_q) begin
					count_n = 8'd0;
					word_n[0] = 32'd0;
					word_n[1] = 32'd0;
					word_n[2] = 32'd0;
					ever_n = 1'b0;
					event_n = crc8frr_pkg::EV_EXPIRED;
				end
			end
		end else if (!in_frame_q) begin
			if (in_byte_s1 == crc8frr_pkg::START_BYTE) begin
				in_frame_n = 1'b1;
				idx_n = '0;
				crc_n = 8'd0;
			end
		end else if (idx_c >= CMP_W'(BUF_DEPTH)) begin
			in_frame_n = 1'b0;
			event_n = crc8frr_pkg::EV_OVERFLOW;
		end else begin
			idx_n = idx_q + IDX_W'(1);
			if (idx_c == CMP_W'(0)) begin
				ftype_n = in_byte_s1;
				crc_n = crc8frr_pkg::crc_step(crc_q, in_byte_s1);
			end else if (idx_c == CMP_W'(1)) begin
				flen_n = in_byte_s1;
				crc_n = crc8frr_pkg::crc_step(crc_q, in_byte_s1);
			end else if (idx_c < len_c + CMP_W'(crc8frr_pkg::HDR_BYTES)) begin
				cap_we = idx_c < CMP_W'(crc8frr_pkg::RECORD_BYTES + crc8frr_pkg::HDR_BYTES);
				crc_n = crc8frr_pkg::crc_step(crc_q, in_byte_s1);
			end else if (idx_c == len_c + CMP_W'(crc8frr_pkg::HDR_BYTES)) begin
				rcrc_n = in_byte_s1;
			end else begin
				in_frame_n = 1'b0;
				priority if (in_byte_s1 != crc8frr_pkg::END_BYTE) begin
					event_n = crc8frr_pkg::EV_BAD_END;
				end else if (crc_q != rcrc_q) begin
					event_n = crc8frr_pkg::EV_CRC_ERR;
				end else if (ftype_q == rec_type_q
						&& flen_q >= 8'(crc8frr_pkg::RECORD_BYTES)) begin
					count_n = cap_q[0];
					word_n[0] = {cap_q[1], cap_q[2], cap_q[3], cap_q[4]};
					word_n[1] = {cap_q[5], cap_q[6], cap_q[7], cap_q[8]};
					word_n[2] = {cap_q[9], cap_q[10], cap_q[11], cap_q[12]};
					ticks_n = 16'd0;
					ever_n = 1'b1;
					event_n = crc8frr_pkg::EV_UPDATED;
				end else begin
					event_n = crc8frr_pkg::EV_OTHER;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= crc8frr_pkg::TIMEOUT_RESET;
			rec_type_q <= crc8frr_pkg::TYPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				crc8frr_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
				crc8frr_pkg::REG_TYPE: rec_type_q <= cfg_data[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_cmd_s1 <= s_tuser;
			in_byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			event_q <= crc8frr_pkg::EV_NONE;
			in_frame_q <= 1'b0;
			idx_q <= '0;
			ftype_q <= 8'd0;
			flen_q <= 8'd0;
			crc_q <= 8'd0;
			rcrc_q <= 8'd0;
			count_q <= 8'd0;
			word_q[0] <= 32'd0;
			word_q[1] <= 32'd0;
			word_q[2] <= 32'd0;
			ticks_q <= 16'd0;
			ever_q <= 1'b0;
		end else begin
			if (m_tready || !out_valid_q) begin
				out_valid_q <= adv;
			end
			if (adv) begin
				event_q <= event_n;
				in_frame_q <= in_frame_n;
				idx_q <= idx_n;
				ftype_q <= ftype_n;
				flen_q <= flen_n;
				crc_q <= crc_n;
				rcrc_q <= rcrc_n;
				count_q <= count_n;
				word_q <= word_n;
				ticks_q <= ticks_n;
				ever_q <= ever_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cap_we) begin
			cap_q[cap_addr] <= in_byte_s1;
		end
	end

endmodule

`default_nettype wire
